/* sv/pfe_pkg.sv */
// Shared types, constants and letter helpers for the Playfair encryption block.
// No dependencies; the top level, sequencer and datapath import this package (the RAM does not).
`default_nettype none
package pfe_pkg;

	localparam int unsigned LETTER_W = 5;
	localparam int unsigned LETTERS  = 26;
	localparam int unsigned CELLS    = 25;
	localparam int unsigned SIDE     = 5;
	localparam int unsigned RC_W     = 3;
	localparam int unsigned CFG_AW   = 3;
	localparam int unsigned CFG_DW   = 32;

	localparam logic [LETTER_W-1:0] LETTER_I   = 5'd8;
	localparam logic [LETTER_W-1:0] LETTER_J   = 5'd9;
	localparam logic [LETTER_W-1:0] LETTER_MAX = 5'd25;
	localparam logic [LETTER_W-1:0] FILLER_RST = 5'd23;
	localparam logic [LETTER_W-1:0] ALT_RST    = 5'd25;

	// Register indexes on the configuration port.
	localparam logic CFG_FILLER = 1'b0;
	localparam logic CFG_ALT    = 1'b1;

	typedef enum logic [2:0] {
		OP_CLEAR    = 3'd0,
		OP_KEY      = 3'd1,
		OP_COMPLETE = 3'd2,
		OP_TEXT     = 3'd3,
		OP_END      = 3'd4
	} op_t;

	typedef struct packed {
		logic clear;
		logic key_write;
		logic walk_start;
		logic walk_step;
		logic set_ready;
		logic hold;
		logic pair_load;
		logic b_filler;
		logic held_drop;
		logic rd_b;
		logic cap_pa;
		logic calc;
		logic sq_sel_b;
		logic cap_ea;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic square_ready;
		logic held_valid;
		logic letter_ok;
		logic doubled;
		logic walk_last;
		logic queue_empty;
	} status_t;

	// Folds j into i on a letter already known to be in range.
	function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] v);
		fold_j = (v == LETTER_J) ? LETTER_I : v;
	endfunction

	// Filler register value as used: clamped to z, j folded to i.
	function automatic logic [LETTER_W-1:0] fold_cfg(input logic [LETTER_W-1:0] v);
		logic [LETTER_W-1:0] c;
		c = (v > LETTER_MAX) ? LETTER_MAX : v;
		fold_cfg = fold_j(c);
	endfunction

	// Cell position reduced below 25.
	function automatic logic [LETTER_W-1:0] cell_wrap(input logic [LETTER_W-1:0] p);
		cell_wrap = (p >= LETTER_W'(CELLS)) ? p - LETTER_W'(CELLS) : p;
	endfunction

	function automatic logic [RC_W-1:0] cell_row(input logic [LETTER_W-1:0] p);
		logic [LETTER_W-1:0] q;
		q = cell_wrap(p);
		if (q >= 5'd20)      cell_row = 3'd4;
		else if (q >= 5'd15) cell_row = 3'd3;
		else if (q >= 5'd10) cell_row = 3'd2;
		else if (q >= 5'd5)  cell_row = 3'd1;
		else                 cell_row = 3'd0;
	endfunction

	function automatic logic [RC_W-1:0] cell_col(input logic [LETTER_W-1:0] p);
		logic [LETTER_W-1:0] q;
		logic [LETTER_W-1:0] base;
		q = cell_wrap(p);
		base = LETTER_W'(cell_row(p)) * LETTER_W'(SIDE);
		cell_col = RC_W'(q - base);
	endfunction

	function automatic logic [RC_W-1:0] rc_inc(input logic [RC_W-1:0] v);
		rc_inc = (v == RC_W'(SIDE - 1)) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [LETTER_W-1:0] cell_index(input logic [RC_W-1:0] row,
		input logic [RC_W-1:0] col);
		cell_index = LETTER_W'(row) * LETTER_W'(SIDE) + LETTER_W'(col);
	endfunction

endpackage
`default_nettype wire

/* sv/playfair_cipher_encrypt.sv */
// Playfair encryption block: key letters build a 5x5 square, text letters are paired and
// encrypted. Clear and key letter finish in their accepting cycle; complete takes that
// cycle, then one alphabet letter per cycle through the shared RAM write port. A letter
// that forms a pair makes four RAM reads through states PA, PB, CALC, EB and OUT: the first
// result shows in the same cycle as input is taken again; a new pair stalls until the last
// one has left. Asynchronous active-low reset clears control state; the RAMs stay undefined.
`default_nettype none
module playfair_cipher_encrypt (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input channel.
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [2:0]                          operation,
	input  wire logic [pfe_pkg::LETTER_W-1:0]        letter,
	// Result channel.
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [pfe_pkg::LETTER_W-1:0]             cipher_letter,
	output logic                                     last,
	// Configuration port.
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [pfe_pkg::CFG_AW-1:0]          paddr,
	input  wire logic [pfe_pkg::CFG_DW-1:0]          pwdata,
	output logic [pfe_pkg::CFG_DW-1:0]               prdata,
	output logic                                     pready
);
	import pfe_pkg::*;

	logic [LETTER_W-1:0] filler_q;
	logic [LETTER_W-1:0] alt_filler_q;
	logic                cfg_write;
	logic                cfg_index;
	cmd_t                cmd;
	status_t             status;

	// The port never stalls. A write transaction lands in its access cycle,
	// and register index is the word address, so only address bit 2 decodes.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_index = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filler_q     <= FILLER_RST;
			alt_filler_q <= ALT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_FILLER: filler_q     <= pwdata[LETTER_W-1:0];
				CFG_ALT:    alt_filler_q <= pwdata[LETTER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Reads return the stored five bits, zero-extended to the bus.
	always_comb begin
		unique case (cfg_index)
			CFG_FILLER: prdata = CFG_DW'(filler_q);
			CFG_ALT:    prdata = CFG_DW'(alt_filler_q);
			default:    prdata = '0;
		endcase
	end

	// The sequencer takes a transaction only when idle; the datapath keeps
	// the square, the held letter and the two-entry result queue, so a
	// finished pair can wait at the output while new transactions arrive.
	pfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.status    (status),
		.cmd       (cmd)
	);

	pfe_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.letter            (letter),
		.filler_letter     (filler_q),
		.alt_filler_letter (alt_filler_q),
		.status            (status),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.cipher_letter     (cipher_letter),
		.last              (last)
	);

endmodule
`default_nettype wire

/* sv/pfe_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module pfe_ram #(
	parameter int unsigned WIDTH = 5,
	parameter int unsigned DEPTH = 25,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* sv/pfe_ctrl.sv */
// Sequencer for the Playfair block: decodes transactions and steps the datapath.
// Depends on pfe_pkg for the command, status and operation types.
`default_nettype none
module pfe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        operation,
	input  wire pfe_pkg::status_t  status,
	output pfe_pkg::cmd_t          cmd
);
	import pfe_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_PA,
		ST_PB,
		ST_CALC,
		ST_EB,
		ST_OUT
	} state_t;

	state_t state_q;
	state_t state_next;
	op_t    op;

	assign op       = op_t'(operation);
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (op)
						OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						OP_KEY: begin
							cmd.key_write = !status.square_ready && status.letter_ok;
						end
						OP_COMPLETE: begin
							if (!status.square_ready) begin
								cmd.walk_start = 1'b1;
								state_next     = ST_WALK;
							end
						end
						OP_TEXT: begin
							if (status.square_ready && status.letter_ok) begin
								if (!status.held_valid) begin
									cmd.hold = 1'b1;
								end else begin
									cmd.pair_load = 1'b1;
									cmd.b_filler  = status.doubled;
									cmd.held_drop = !status.doubled;
									state_next    = ST_PA;
								end
							end
						end
						OP_END: begin
							if (status.square_ready && status.held_valid) begin
								cmd.pair_load = 1'b1;
								cmd.b_filler  = 1'b1;
								cmd.held_drop = 1'b1;
								state_next    = ST_PA;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (status.walk_last) begin
					cmd.set_ready = 1'b1;
					state_next    = ST_IDLE;
				end
			end
			ST_PA: begin
				state_next = ST_PB;
			end
			ST_PB: begin
				cmd.rd_b   = 1'b1;
				cmd.cap_pa = 1'b1;
				state_next = ST_CALC;
			end
			ST_CALC: begin
				cmd.rd_b   = 1'b1;
				cmd.calc   = 1'b1;
				state_next = ST_EB;
			end
			ST_EB: begin
				cmd.sq_sel_b = 1'b1;
				cmd.cap_ea   = 1'b1;
				state_next   = ST_OUT;
			end
			ST_OUT: begin
				cmd.sq_sel_b = 1'b1;
				if (status.queue_empty) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule
`default_nettype wire

/* sv/pfe_datapath.sv */
// Datapath of the Playfair block: square and letter-place RAMs, pair
// registers, cell arithmetic and the two-entry result queue. Uses pfe_pkg, pfe_ram.
`default_nettype none
module pfe_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pfe_pkg::cmd_t                 cmd,
	input  wire logic [pfe_pkg::LETTER_W-1:0]  letter,
	input  wire logic [pfe_pkg::LETTER_W-1:0]  filler_letter,
	input  wire logic [pfe_pkg::LETTER_W-1:0]  alt_filler_letter,
	output pfe_pkg::status_t                   status,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [pfe_pkg::LETTER_W-1:0]       cipher_letter,
	output logic                               last
);
	import pfe_pkg::*;

	logic [LETTERS-1:0]  used_q;
	logic [LETTER_W-1:0] fill_q;
	logic                ready_q;
	logic [LETTER_W-1:0] held_q;
	logic                held_valid_q;
	logic [LETTER_W-1:0] walk_q;
	logic [LETTER_W-1:0] a_q;
	logic [LETTER_W-1:0] b_q;
	logic [LETTER_W-1:0] pa_q;
	logic [LETTER_W-1:0] eb_addr_q;
	logic [LETTER_W-1:0] ea_q;
	logic                out_valid_q;
	logic [LETTER_W-1:0] out_letter_q;
	logic                out_last_q;
	logic                pend_q;
	logic [LETTER_W-1:0] pend_letter_q;

	logic [LETTER_W-1:0] v_in;
	logic [LETTER_W-1:0] filler;
	logic [LETTER_W-1:0] v_place;
	logic                place_we;
	logic [LETTER_W-1:0] place_raddr;
	logic [LETTER_W-1:0] place_rdata;
	logic [LETTER_W-1:0] sq_raddr;
	logic [LETTER_W-1:0] sq_rdata;
	logic [RC_W-1:0]     r1, c1, r2, c2;
	logic [LETTER_W-1:0] ea_addr;
	logic [LETTER_W-1:0] eb_addr;

	assign v_in   = fold_j(letter);
	assign filler = (held_q == fold_cfg(filler_letter)) ? fold_cfg(alt_filler_letter)
		: fold_cfg(filler_letter);

	// A letter lands in the next free cell unless it is a walked j, already placed or the square is full.
	assign v_place  = cmd.walk_step ? walk_q : v_in;
	assign place_we = (cmd.key_write || (cmd.walk_step && walk_q != LETTER_J))
		&& !used_q[v_place] && (fill_q < LETTER_W'(CELLS));

	assign place_raddr = cmd.rd_b ? b_q : a_q;

	pfe_ram #(.WIDTH(LETTER_W), .DEPTH(LETTERS)) u_place (
		.clk   (clk),
		.we    (place_we),
		.waddr (v_place),
		.wdata (fill_q),
		.raddr (place_raddr),
		.rdata (place_rdata)
	);

	// Cell arithmetic: pa_q holds the place of the first letter, the RAM
	// output the place of the second.
	always_comb begin
		r1 = cell_row(pa_q);
		c1 = cell_col(pa_q);
		r2 = cell_row(place_rdata);
		c2 = cell_col(place_rdata);
		if (r1 == r2) begin
			ea_addr = cell_index(r1, rc_inc(c1));
			eb_addr = cell_index(r2, rc_inc(c2));
		end else if (c1 == c2) begin
			ea_addr = cell_index(rc_inc(r1), c1);
			eb_addr = cell_index(rc_inc(r2), c2);
		end else begin
			ea_addr = cell_index(r1, c2);
			eb_addr = cell_index(r2, c1);
		end
	end

	assign sq_raddr = cmd.sq_sel_b ? eb_addr_q : ea_addr;

	pfe_ram #(.WIDTH(LETTER_W), .DEPTH(CELLS)) u_square (
		.clk   (clk),
		.we    (place_we),
		.waddr (fill_q),
		.wdata (v_place),
		.raddr (sq_raddr),
		.rdata (sq_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.pair_load) begin
			a_q <= held_q;
			b_q <= cmd.b_filler ? filler : v_in;
		end
		if (cmd.cap_pa) begin
			pa_q <= place_rdata;
		end
		if (cmd.calc) begin
			eb_addr_q <= eb_addr;
		end
		if (cmd.cap_ea) begin
			ea_q <= sq_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q        <= '0;
			fill_q        <= '0;
			ready_q       <= 1'b0;
			held_q        <= '0;
			held_valid_q  <= 1'b0;
			walk_q        <= '0;
			out_valid_q   <= 1'b0;
			out_letter_q  <= '0;
			out_last_q    <= 1'b0;
			pend_q        <= 1'b0;
			pend_letter_q <= '0;
		end else begin
			if (cmd.clear) begin
				used_q       <= '0;
				fill_q       <= '0;
				ready_q      <= 1'b0;
				held_q       <= '0;
				held_valid_q <= 1'b0;
			end else begin
				if (place_we) begin
					used_q[v_place] <= 1'b1;
					fill_q          <= fill_q + 1'b1;
				end
				if (cmd.set_ready) begin
					ready_q <= 1'b1;
				end
				if (cmd.hold) begin
					held_q       <= v_in;
					held_valid_q <= 1'b1;
				end
				if (cmd.pair_load && cmd.held_drop) begin
					held_valid_q <= 1'b0;
				end
			end
			if (cmd.walk_start) begin
				walk_q <= '0;
			end else if (cmd.walk_step) begin
				walk_q <= walk_q + 1'b1;
			end
			// Result queue: the head drives the port, the second letter waits.
			if (cmd.out_load) begin
				out_valid_q   <= 1'b1;
				out_letter_q  <= ea_q;
				out_last_q    <= 1'b0;
				pend_q        <= 1'b1;
				pend_letter_q <= sq_rdata;
			end else if (out_valid_q && out_ready) begin
				out_valid_q  <= pend_q;
				out_letter_q <= pend_letter_q;
				out_last_q   <= 1'b1;
				pend_q       <= 1'b0;
			end
		end
	end

	always_comb begin
		status.square_ready = ready_q;
		status.held_valid   = held_valid_q;
		status.letter_ok    = (letter <= LETTER_MAX);
		status.doubled      = (v_in == held_q);
		status.walk_last    = (walk_q == LETTER_W'(LETTERS - 1));
		status.queue_empty  = !out_valid_q && !pend_q;
	end

	assign out_valid     = out_valid_q;
	assign cipher_letter = out_letter_q;
	assign last          = out_last_q;

	a_pend_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q)
		else $error("second letter waiting without a head entry");

	a_load_into_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q && !pend_q))
		else $error("pair loaded into a busy result queue");

	a_clear_effect: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (!ready_q && !held_valid_q && fill_q == '0 && used_q == '0))
		else $error("clear did not empty the square");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LETTER_W'(CELLS))
		else $error("fill count ran past the square");

endmodule
`default_nettype wire
